### hw/rtl/dfpa_pkg.sv
// ----------------------------------------------------------------------------
// dfpa_pkg
// Shared types and constants of the dynamic-range fixed-point ALU.
// ----------------------------------------------------------------------------
package dfpa_pkg;

  // Default largest integer length; the length registers hold up to 63.
  localparam int DFPA_MAX_INT_LEN = 31;
  localparam int LEN_W = 6;

  localparam logic [2:0] MODE_ADD = 3'd0;
  localparam logic [2:0] MODE_SUB = 3'd1;
  localparam logic [2:0] MODE_MUL = 3'd2;
  localparam logic [2:0] MODE_DIV = 3'd3;
  localparam logic [2:0] MODE_GT  = 3'd4;
  localparam logic [2:0] MODE_EQ  = 3'd5;

  typedef enum logic [3:0] {
    S_IDLE, S_SETUP, S_DISPATCH, S_MUL, S_LZC, S_DIVPREP,
    S_DIVITER, S_NORM, S_FIN, S_DONE
  } dfpa_state_t;

  typedef enum logic [3:0] {
    CMD_NONE, CMD_LOAD, CMD_SETUP, CMD_MUL, CMD_LZC_STEP,
    CMD_DIVPREP, CMD_DIV_STEP, CMD_NORM_STEP, CMD_FINISH
  } dfpa_cmd_t;

  typedef struct packed {
    logic [2:0] mode;
    logic       decided;
    logic       grow;
    logic       lzc_done;
    logic       iter_last;
    logic       norm_done;
  } dfpa_status_t;

endpackage

### hw/rtl/dfpa_ctrl.sv
// ----------------------------------------------------------------------------
// dfpa_ctrl
// Sequencer that steps the datapath through one operation.
// ----------------------------------------------------------------------------
module dfpa_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  dfpa_pkg::dfpa_status_t status,
  output dfpa_pkg::dfpa_cmd_t   cmd,
  output logic                  busy,
  output logic                  done
);
  import dfpa_pkg::*;

  dfpa_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:     if (start) state_next = S_SETUP;
      S_SETUP:    state_next = S_DISPATCH;
      S_DISPATCH: begin
        case (status.mode) inside
          MODE_ADD, MODE_SUB: state_next = S_NORM;
          MODE_MUL:           state_next = S_MUL;
          MODE_DIV: begin
            if (status.decided) state_next = S_FIN;
            else if (status.grow) state_next = S_LZC;
            else state_next = S_DIVPREP;
          end
          default:            state_next = S_FIN;
        endcase
      end
      S_MUL:      state_next = S_NORM;
      S_LZC:      if (status.lzc_done) state_next = S_DIVPREP;
      S_DIVPREP:  state_next = S_DIVITER;
      S_DIVITER: begin
        if (status.decided) state_next = S_FIN;
        else if (status.iter_last) state_next = S_NORM;
      end
      S_NORM:     if (status.norm_done) state_next = S_FIN;
      S_FIN:      state_next = S_DONE;
      S_DONE:     state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd  = CMD_NONE;
    busy = (state != S_IDLE);
    done = 1'b0;
    unique case (state)
      S_IDLE:     if (start) cmd = CMD_LOAD;
      S_SETUP:    cmd = CMD_SETUP;
      S_DISPATCH: cmd = CMD_NONE;
      S_MUL:      cmd = CMD_MUL;
      S_LZC:      if (!status.lzc_done) cmd = CMD_LZC_STEP;
      S_DIVPREP:  cmd = CMD_DIVPREP;
      S_DIVITER:  if (!status.decided) cmd = CMD_DIV_STEP;
      S_NORM:     if (!status.norm_done) cmd = CMD_NORM_STEP;
      S_FIN:      cmd = CMD_FINISH;
      S_DONE:     done = 1'b1;
      default:    cmd = CMD_NONE;
    endcase
  end

endmodule

### hw/rtl/dfpa_dp.sv
// ----------------------------------------------------------------------------
// dfpa_dp
// Operand registers, shifters, multiplier, radix-2 divider and normalizer.
// ----------------------------------------------------------------------------
module dfpa_dp #(
  parameter int MAX_INT_LEN = dfpa_pkg::DFPA_MAX_INT_LEN
) (
  input  logic                   clk,
  input  dfpa_pkg::dfpa_cmd_t    cmd,
  input  logic [2:0]             mode,
  input  logic signed [31:0]     a_value,
  input  logic [4:0]             a_int_len,
  input  logic signed [31:0]     b_value,
  input  logic [4:0]             b_int_len,
  output dfpa_pkg::dfpa_status_t status,
  output logic signed [31:0]     result_value,
  output logic [4:0]             result_int_len,
  output logic                   compare_flag,
  output logic                   saturated
);
  import dfpa_pkg::*;

  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_INT_LEN);

  logic [2:0]             mode_q;
  logic signed [31:0]     x, y;
  logic [4:0]             al, bl, tl, cnt;
  logic signed [31:0]     res_val;
  logic [LEN_W-1:0]       res_len;
  logic                   res_sat, flag, decided, grow, div_neg, neg_apply;
  logic signed [63:0]     prod;
  logic [31:0]            mx, my, sh, rem;
  logic [30:0]            qd;

  // Add and subtract alignment, and the multiply, compare and divide terms.
  logic [4:0]             lmax, shx, shy;
  logic [LEN_W-1:0]       l_as, l_mul, l_div;
  logic signed [31:0]     hx, hy, sum;
  logic signed [63:0]     cx, cy, q_mul;
  logic [31:0]            ax, ay, mx_al, my_al;
  logic [4:0]             s_div, s_mul;
  logic [61:0]            dvd;
  logic [32:0]            trial;
  logic                   ge;
  logic [30:0]            qd_n;

  always_comb begin
    lmax = (al > bl) ? al : bl;
    l_as = {1'b0, lmax} + LEN_W'(1);
    if (al > bl) begin
      shx = 5'd1;
      shy = al - bl + 5'd1;
    end else if (al < bl) begin
      shx = bl - al + 5'd1;
      shy = 5'd1;
    end else begin
      shx = 5'd1;
      shy = 5'd1;
    end
    hx  = x >>> shx;
    hy  = y >>> shy;
    sum = (mode_q == MODE_SUB) ? (hx - hy) : (hx + hy);

    l_mul = {1'b0, al} + {1'b0, bl};
    s_mul = 5'(6'd31 - l_mul);
    q_mul = prod >>> s_mul;

    cx = 64'(x) <<< al;
    cy = 64'(y) <<< bl;

    ax    = x[31] ? (~x + 32'd1) : x;
    ay    = y[31] ? (~y + 32'd1) : y;
    mx_al = (bl > al) ? (ax >> (bl - al)) : ax;
    my_al = (al > bl) ? (ay >> (al - bl)) : ay;

    l_div = grow ? {1'b0, cnt} : {1'b0, tl};
    s_div = 5'(6'd31 - l_div);
    dvd   = {30'd0, mx} << s_div;

    trial = {rem, qd[30]};
    ge    = trial >= {1'b0, my};
    qd_n  = {qd[29:0], ge};
  end

  always_ff @(posedge clk) begin
    case (cmd)
      CMD_LOAD: begin
        mode_q    <= mode;
        x         <= a_value;
        y         <= b_value;
        al        <= (a_int_len == 5'd0) ? 5'd1 : a_int_len;
        bl        <= (b_int_len == 5'd0) ? 5'd1 : b_int_len;
        res_val   <= '0;
        res_len   <= LEN_W'(1);
        res_sat   <= 1'b0;
        flag      <= 1'b0;
        decided   <= 1'b0;
        grow      <= 1'b0;
        neg_apply <= 1'b0;
      end
      CMD_SETUP: begin
        case (mode_q) inside
          MODE_ADD, MODE_SUB: begin
            if (l_as > MAX_LEN) begin
              res_val <= 32'sh7FFFFFFF;
              res_len <= MAX_LEN;
              res_sat <= 1'b1;
              decided <= 1'b1;
            end else begin
              res_val <= sum;
              res_len <= l_as;
            end
          end
          MODE_MUL: begin
            if (l_mul > MAX_LEN) begin
              res_val <= (x[31] ^ y[31]) ? 32'sh80000000 : 32'sh7FFFFFFF;
              res_len <= MAX_LEN;
              res_sat <= 1'b1;
              decided <= 1'b1;
            end
            prod <= (x >>> bl) * (y >>> al);
          end
          MODE_DIV: begin
            div_neg <= x[31] ^ y[31];
            mx      <= mx_al;
            my      <= my_al;
            sh      <= my_al;
            cnt     <= '0;
            tl      <= lmax;
            grow    <= (my_al >> (5'd31 - lmax)) == 32'd0;
            if (y == 32'sd0 || my_al == 32'd0) begin
              res_val <= (x[31] ^ y[31]) ? 32'sh80000000 : 32'sh7FFFFFFF;
              res_len <= MAX_LEN;
              res_sat <= 1'b1;
              decided <= 1'b1;
            end else if (mx_al == 32'd0) begin
              decided <= 1'b1;
            end
          end
          MODE_GT: begin
            flag    <= cx > cy;
            decided <= 1'b1;
          end
          MODE_EQ: begin
            flag    <= (x == y) && (al == bl);
            decided <= 1'b1;
          end
          default: decided <= 1'b1;
        endcase
      end
      CMD_MUL: begin
        if (!decided) begin
          if (q_mul[63:31] != {33{q_mul[63]}}) begin
            res_val <= q_mul[63] ? 32'sh80000000 : 32'sh7FFFFFFF;
            res_len <= MAX_LEN;
            res_sat <= 1'b1;
            decided <= 1'b1;
          end else begin
            res_val <= q_mul[31:0];
            res_len <= l_mul;
          end
        end
      end
      CMD_LZC_STEP: begin
        sh  <= sh << 1;
        cnt <= cnt + 5'd1;
      end
      CMD_DIVPREP: begin
        cnt <= '0;
        if ((grow && (l_div > MAX_LEN)) || ({1'b0, dvd[61:31]} >= my)) begin
          res_val <= div_neg ? 32'sh80000000 : 32'sh7FFFFFFF;
          res_len <= MAX_LEN;
          res_sat <= 1'b1;
          decided <= 1'b1;
        end else begin
          rem       <= {1'b0, dvd[61:31]};
          qd        <= dvd[30:0];
          res_len   <= l_div;
          neg_apply <= div_neg;
        end
      end
      CMD_DIV_STEP: begin
        rem     <= ge ? 32'(trial - {1'b0, my}) : trial[31:0];
        qd      <= qd_n;
        res_val <= {1'b0, qd_n};
        cnt     <= cnt + 5'd1;
      end
      CMD_NORM_STEP: begin
        res_val <= {res_val[30:0], res_val[31]};
        res_len <= res_len - LEN_W'(1);
      end
      CMD_FINISH: begin
        if (neg_apply) res_val <= -res_val;
      end
      default: ;
    endcase
  end

  always_comb begin
    status.mode      = mode_q;
    status.decided   = decided;
    status.grow      = grow;
    status.lzc_done  = sh[31];
    status.iter_last = (cnt == 5'd30);
    status.norm_done = decided || (res_len <= LEN_W'(1)) || (res_val[30] ^ res_val[31]);
  end

  assign result_value   = res_val;
  assign result_int_len = (res_len > LEN_W'(31)) ? 5'd31 : res_len[4:0];
  assign compare_flag   = flag;
  assign saturated      = res_sat;

endmodule

### hw/rtl/dynamic_fixed_point_alu.sv
// ----------------------------------------------------------------------------
// dynamic_fixed_point_alu
// Fixed-point ALU whose operands each carry their own integer length.
// ----------------------------------------------------------------------------
// A transfer is taken when start is high while busy is low; busy then stays
// high until the result has been shown. The result appears on the result
// ports for exactly one cycle with done high, and the receiver cannot stall
// it, so it must capture the result in that cycle. One operation is in
// flight at a time. Compares go straight to the finish. Add and subtract
// end in the serial normalizer. Multiply also ends in normalization; its
// single 32x32 multiplier is registered before the product shift. Divide
// is the longest: a serial leading-zero count of the divisor when it is
// below one, a radix-2 restoring divide and the serial normalizer. The
// normalizer and the leading-zero count shift one bit a cycle.
// ----------------------------------------------------------------------------
module dynamic_fixed_point_alu #(
  parameter int MAX_INT_LEN = dfpa_pkg::DFPA_MAX_INT_LEN
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         mode,
  input  logic signed [31:0] a_value,
  input  logic [4:0]         a_int_len,
  input  logic signed [31:0] b_value,
  input  logic [4:0]         b_int_len,
  output logic               done,
  output logic signed [31:0] result_value,
  output logic [4:0]         result_int_len,
  output logic               compare_flag,
  output logic               saturated
);
  import dfpa_pkg::*;

  dfpa_cmd_t    cmd;
  dfpa_status_t status;

  // The sequencer sees only start and the datapath status; all arithmetic lives in the datapath.
  dfpa_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  dfpa_dp #(
    .MAX_INT_LEN (MAX_INT_LEN)
  ) u_dp (
    .clk            (clk),
    .cmd            (cmd),
    .mode           (mode),
    .a_value        (a_value),
    .a_int_len      (a_int_len),
    .b_value        (b_value),
    .b_int_len      (b_int_len),
    .status         (status),
    .result_value   (result_value),
    .result_int_len (result_int_len),
    .compare_flag   (compare_flag),
    .saturated      (saturated)
  );

  // The done strobe lasts one cycle and the block is then free again.
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done && !busy)
    else $error("done strobe longer than one cycle");

  // An accepted transfer makes the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy && !done)
    else $error("accepted transfer did not raise busy");

  // A saturated result is always one of the two extreme words.
  a_sat_word: assert property (@(posedge clk) disable iff (rst)
    (done && saturated) |-> (result_value == 32'sh7FFFFFFF ||
                             result_value == 32'sh80000000))
    else $error("saturated result is not an extreme word");

  // A delivered integer length is never zero.
  a_len_nonzero: assert property (@(posedge clk) disable iff (rst)
    done |-> (result_int_len != 5'd0))
    else $error("zero integer length delivered");

endmodule

### tb/dfpa_checker.sv
// ----------------------------------------------------------------------------
// dfpa_checker
// Watches the operand and result transfers of the fixed-point ALU, predicts
// every result and compares it field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module dfpa_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [2:0]  mode,
  input  logic [31:0] a_value,
  input  logic [4:0]  a_int_len,
  input  logic [31:0] b_value,
  input  logic [4:0]  b_int_len,
  input  logic        done,
  input  logic [31:0] result_value,
  input  logic [4:0]  result_int_len,
  input  logic        compare_flag,
  input  logic        saturated,
  output int          errors,
  output int          pending
);
  import dfpa_pkg::*;

  localparam int LEN_LIMIT = 31;

  typedef struct {
    logic [31:0] value;
    int          len;
    logic        flag;
    logic        sat;
  } fx_result_t;

  fx_result_t awaited_q[$];

  function automatic longint shift_right_arith(longint v, int s);
    if (s > 63) s = 63;
    return v >>> s;
  endfunction

  function automatic fx_result_t saturate_fx(logic negative);
    fx_result_t r;
    r.value = negative ? 32'h8000_0000 : 32'h7FFF_FFFF;
    r.len   = LEN_LIMIT;
    r.flag  = 1'b0;
    r.sat   = 1'b1;
    return r;
  endfunction

  // Shift out redundant sign bits until bit 30 differs from the sign or the length is one.
  function automatic fx_result_t minimize_len(fx_result_t r);
    logic [31:0] t;
    logic        negative;
    if (r.len < 2) return r;
    negative = r.value[31];
    t = negative ? ~r.value : r.value;
    while (!t[30] && r.len > 1) begin
      t = t << 1;
      r.len--;
    end
    r.value = negative ? ~t : t;
    return r;
  endfunction

  function automatic fx_result_t add_sub_fx(longint x, int al, longint y, int bl, logic sub);
    fx_result_t r;
    longint     hx, hy, s;
    int         len;
    len = ((al > bl) ? al : bl) + 1;
    if (len > LEN_LIMIT) return saturate_fx(1'b0);
    if (al > bl) begin
      hx = shift_right_arith(x, 1);
      hy = shift_right_arith(y, al - bl + 1);
    end else if (al < bl) begin
      hx = shift_right_arith(x, bl - al + 1);
      hy = shift_right_arith(y, 1);
    end else begin
      hx = shift_right_arith(x, 1);
      hy = shift_right_arith(y, 1);
    end
    s = sub ? hx - hy : hx + hy;
    r.value = s[31:0];
    r.len   = len;
    r.flag  = 1'b0;
    r.sat   = 1'b0;
    return minimize_len(r);
  endfunction

  function automatic fx_result_t multiply_fx(longint x, int al, longint y, int bl);
    fx_result_t r;
    longint     p, q;
    int         len;
    len = al + bl;
    if (len > LEN_LIMIT) return saturate_fx((x < 0) != (y < 0));
    p = shift_right_arith(x, bl) * shift_right_arith(y, al);
    q = shift_right_arith(p, (31 - len) & 31);
    if (q > 64'sd2147483647) return saturate_fx(1'b0);
    if (q < -64'sd2147483648) return saturate_fx(1'b1);
    r.value = q[31:0];
    r.len   = len;
    r.flag  = 1'b0;
    r.sat   = 1'b0;
    return minimize_len(r);
  endfunction

  function automatic fx_result_t divide_fx(longint x, int al, longint y, int bl);
    fx_result_t  r;
    logic        negative;
    logic [63:0] mx, my, q;
    int          len, tl, p;
    negative = (x < 0) != (y < 0);
    mx = (x < 0) ? -x : x;
    my = (y < 0) ? -y : y;
    len = al;
    tl  = al;
    r.flag = 1'b0;
    r.sat  = 1'b0;
    if (y == 0) return saturate_fx(negative);
    if (al > bl) begin
      my = my >> (al - bl);
      if (my == 0) return saturate_fx(negative);
    end else if (bl > al) begin
      mx  = mx >> (bl - al);
      tl  = bl;
      len = bl;
      if (mx == 0) begin
        r.value = '0;
        r.len   = 1;
        return r;
      end
    end
    // A divisor below one grows the integer length of the quotient.
    if (my < (64'd1 << (31 - tl))) begin
      p = 0;
      while (p < 63 && (my >> (p + 1)) != 0) p++;
      len = 31 - p;
      if (len > LEN_LIMIT) return saturate_fx(negative);
    end
    q = (mx << (31 - len)) / my;
    if (q > 64'h7FFF_FFFF) return saturate_fx(negative);
    r.value = q[31:0];
    r.len   = len;
    r = minimize_len(r);
    if (negative) r.value = -r.value;
    return r;
  endfunction

  function automatic fx_result_t predict_alu(logic [2:0] op, logic [31:0] av, logic [4:0] alen,
                                             logic [31:0] bv, logic [4:0] blen);
    fx_result_t r;
    longint     x, y;
    int         al, bl;
    x  = longint'(signed'(av));
    y  = longint'(signed'(bv));
    al = (alen == 0) ? 1 : int'(alen);
    bl = (blen == 0) ? 1 : int'(blen);
    r.value = '0;
    r.len   = 1;
    r.flag  = 1'b0;
    r.sat   = 1'b0;
    case (op)
      MODE_ADD: r = add_sub_fx(x, al, y, bl, 1'b0);
      MODE_SUB: r = add_sub_fx(x, al, y, bl, 1'b1);
      MODE_MUL: r = multiply_fx(x, al, y, bl);
      MODE_DIV: r = divide_fx(x, al, y, bl);
      MODE_GT:  r.flag = ((x <<< al) > (y <<< bl));
      MODE_EQ:  r.flag = (x == y) && (al == bl);
      default: ;
    endcase
    if (r.len > 31) r.len = 31;
    return r;
  endfunction

  assign pending = awaited_q.size();

  always @(posedge clk) begin
    fx_result_t e;
    if (rst) begin
      awaited_q.delete();
      errors = 0;
    end else begin
      if (start && !busy)
        awaited_q.push_back(predict_alu(mode, a_value, a_int_len, b_value, b_int_len));
      if (done) begin
        if (awaited_q.size() == 0) begin
          $display("%0t: result with no operation outstanding: value %h len %0d",
                   $time, result_value, result_int_len);
          errors++;
        end else begin
          e = awaited_q.pop_front();
          if (result_value !== e.value) begin
            $display("%0t: result_value expected %h actual %h", $time, e.value, result_value);
            errors++;
          end
          if (result_int_len !== e.len[4:0]) begin
            $display("%0t: result_int_len expected %0d actual %0d",
                     $time, e.len, result_int_len);
            errors++;
          end
          if (compare_flag !== e.flag) begin
            $display("%0t: compare_flag expected %b actual %b", $time, e.flag, compare_flag);
            errors++;
          end
          if (saturated !== e.sat) begin
            $display("%0t: saturated expected %b actual %b", $time, e.sat, saturated);
            errors++;
          end
        end
      end
    end
  end

endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives directed and random operations into the fixed-point ALU; a checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import dfpa_pkg::*;

  localparam int RANDOM_ITEMS = 2000;
  // Cycle limit for the whole run, with a wide margin per item over the slowest operation.
  localparam int CYCLE_LIMIT  = 2_000_000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  mode = MODE_ADD;
  logic [31:0] a_value = '0;
  logic [4:0]  a_int_len = 5'd1;
  logic [31:0] b_value = '0;
  logic [4:0]  b_int_len = 5'd1;
  logic        done;
  logic [31:0] result_value;
  logic [4:0]  result_int_len;
  logic        compare_flag;
  logic        saturated;
  int          errors;
  int          pending;
  int          cycles = 0;

  always #4 clk = ~clk;

  dynamic_fixed_point_alu dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .mode(mode), .a_value(a_value), .a_int_len(a_int_len),
    .b_value(b_value), .b_int_len(b_int_len),
    .done(done), .result_value(result_value), .result_int_len(result_int_len),
    .compare_flag(compare_flag), .saturated(saturated)
  );

  dfpa_checker u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .mode(mode), .a_value(a_value), .a_int_len(a_int_len),
    .b_value(b_value), .b_int_len(b_int_len),
    .done(done), .result_value(result_value), .result_int_len(result_int_len),
    .compare_flag(compare_flag), .saturated(saturated),
    .errors(errors), .pending(pending)
  );

  // The watchdog counts cycles and ends a run that has hung.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Presents one operation and holds it until the transfer happens. Busy is
  // sampled on the falling edge so that the decision never races the block's
  // own update at the rising edge; the caller is left at the edge of the
  // transfer and decides there whether start stays high.
  task automatic issue_op(logic [2:0] op, logic [31:0] av, logic [4:0] al,
                          logic [31:0] bv, logic [4:0] bl);
    start     <= 1'b1;
    mode      <= op;
    a_value   <= av;
    a_int_len <= al;
    b_value   <= bv;
    b_int_len <= bl;
    forever begin
      @(negedge clk);
      if (!busy) break;
    end
    @(posedge clk);
  endtask

  task automatic idle_cycle();
    start <= 1'b0;
    @(posedge clk);
  endtask

  // Operand words: mostly of random magnitude so that the integer lengths
  // meet both small and large values, with the extremes now and then.
  function automatic logic [31:0] random_word();
    logic [31:0] w;
    case ($urandom_range(0, 9))
      0: w = 32'h8000_0000;
      1: w = 32'h7FFF_FFFF;
      2: w = '0;
      3: w = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0001;
      default: w = $signed($urandom()) >>> $urandom_range(0, 31);
    endcase
    return w;
  endfunction

  // Short lengths keep most arithmetic away from saturation; zero and the
  // top lengths still come up.
  function automatic logic [4:0] random_len();
    if ($urandom_range(0, 3) == 0) return 5'($urandom_range(0, 31));
    return 5'($urandom_range(1, 15));
  endfunction

  initial begin
    logic [2:0] op;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: every operation, the word and length extremes,
    // division by zero, a dividend that aligns to zero, length overflow,
    // equal and unequal compares, and the two unused modes.
    issue_op(MODE_ADD, 32'h7FFF_FFFF, 5'd1, 32'h7FFF_FFFF, 5'd1);
    issue_op(MODE_ADD, 32'h8000_0000, 5'd30, 32'h8000_0000, 5'd30);
    issue_op(MODE_ADD, 32'h4000_0000, 5'd31, 32'h1, 5'd2);
    issue_op(MODE_SUB, 32'h8000_0000, 5'd3, 32'h7FFF_FFFF, 5'd9);
    issue_op(MODE_SUB, 32'h1234_5678, 5'd0, 32'h1234_5678, 5'd0);
    issue_op(MODE_MUL, 32'h7FFF_FFFF, 5'd15, 32'h7FFF_FFFF, 5'd16);
    issue_op(MODE_MUL, 32'h8000_0000, 5'd16, 32'h7FFF_FFFF, 5'd16);
    issue_op(MODE_MUL, 32'h8000_0000, 5'd1, 32'h8000_0000, 5'd1);
    issue_op(MODE_MUL, 32'h4000_0000, 5'd2, 32'hC000_0000, 5'd3);
    issue_op(MODE_DIV, 32'h4000_0000, 5'd4, 32'h0, 5'd4);
    issue_op(MODE_DIV, 32'h8000_0000, 5'd4, 32'h0, 5'd9);
    issue_op(MODE_DIV, 32'h4000_0000, 5'd31, 32'h1, 5'd1);
    issue_op(MODE_DIV, 32'h1, 5'd1, 32'h4000_0000, 5'd31);
    issue_op(MODE_DIV, 32'h7FFF_FFFF, 5'd8, 32'h0000_0100, 5'd8);
    issue_op(MODE_DIV, 32'h8000_0000, 5'd2, 32'h7FFF_FFFF, 5'd2);
    issue_op(MODE_GT, 32'hFFFF_FFFF, 5'd3, 32'hFFFF_FFFF, 5'd5);
    issue_op(MODE_GT, 32'h7FFF_FFFF, 5'd31, 32'h8000_0000, 5'd31);
    issue_op(MODE_GT, 32'h8000_0000, 5'd1, 32'h7FFF_FFFF, 5'd1);
    issue_op(MODE_EQ, 32'h5555_5555, 5'd7, 32'h5555_5555, 5'd7);
    issue_op(MODE_EQ, 32'h5555_5555, 5'd7, 32'h5555_5555, 5'd8);
    issue_op(3'd6, 32'hFFFF_FFFF, 5'd31, 32'hFFFF_FFFF, 5'd31);
    issue_op(3'd7, 32'h0, 5'd0, 32'h0, 5'd0);

    // Random part; items 800 to 1199 run back to back with no idling.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if ((i < 800 || i >= 1200) && $urandom_range(0, 99) < 24) begin
        repeat ($urandom_range(1, 6)) idle_cycle();
      end
      op = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
                                        : 3'($urandom_range(0, 5));
      issue_op(op, random_word(), random_len(), random_word(), random_len());
    end
    start <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (120) @(posedge clk);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
